### src/dimmer_ramp_controller_assert.svh
// Assertion macros for the dimmer ramp controller.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef DIMMER_RAMP_CONTROLLER_ASSERT_SVH
`define DIMMER_RAMP_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge
`define DRC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dimmer ramp controller check failed");
// expression must never be true
`define DRC_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("dimmer ramp controller forbidden condition");
`else
`define DRC_ASSERT(label, prop)
`define DRC_NEVER(label, expr)
`endif
`endif

### src/drc_pkg.sv
`default_nettype none
package drc_pkg;

	// fixed field widths
	localparam int unsigned LVL_W         = 8;
	localparam int unsigned DUR_W         = 15;
	localparam int unsigned PER_W         = 16;
	localparam int unsigned ON_DLY_W      = 16;
	localparam int unsigned OFF_DLY_W     = 32;
	localparam int unsigned REQ_W         = 4;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned CFG_DATA_W    = 32;
	localparam int unsigned TIME_BITS_DEF = 32;

	// register reset values
	localparam logic [LVL_W-1:0] RST_MIN_LEVEL = 8'd0;
	localparam logic [LVL_W-1:0] RST_MAX_LEVEL = 8'd255;
	localparam logic [DUR_W-1:0] RST_ABS_DUR   = 15'd500;
	localparam logic [DUR_W-1:0] RST_REL_DUR   = 15'd5000;

	// request codes of the input item
	typedef enum logic [REQ_W-1:0] {
		REQ_TICK        = 4'd0,
		REQ_STOP        = 4'd1,
		REQ_ON          = 4'd2,
		REQ_OFF         = 4'd3,
		REQ_TOGGLE      = 4'd4,
		REQ_SOFT_ON     = 4'd5,
		REQ_SOFT_OFF    = 4'd6,
		REQ_TOGGLE_SOFT = 4'd7,
		REQ_UP          = 4'd8,
		REQ_DOWN        = 4'd9,
		REQ_TOGGLE_DIM  = 4'd10,
		REQ_SET         = 4'd11,
		REQ_CLEAR       = 4'd12
	} req_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LEVEL  = 3'd0,
		REG_MAX_LEVEL  = 3'd1,
		REG_ABS_DUR    = 3'd2,
		REG_REL_DUR    = 3'd3,
		REG_ON_DELAY   = 3'd4,
		REG_OFF_DELAY  = 3'd5,
		REG_CHANNEL_ID = 3'd6
	} cfg_reg_t;

	// selected dimmer task
	typedef enum logic [3:0] {
		T_IDLE    = 4'd0,
		T_STOP    = 4'd1,
		T_ON      = 4'd2,
		T_OFF     = 4'd3,
		T_SOFTON  = 4'd4,
		T_SOFTOFF = 4'd5,
		T_UP      = 4'd6,
		T_DOWN    = 4'd7,
		T_SET     = 4'd8
	} task_t;

	// power supply sequencer phase
	typedef enum logic [1:0] {
		PH_OFF      = 2'd0,
		PH_ON_WAIT  = 2'd1,
		PH_ON       = 2'd2,
		PH_OFF_WAIT = 2'd3
	} phase_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EVAL  = 2'd1,
		ST_DIV   = 2'd2,
		ST_APPLY = 2'd3
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic tick;
		logic div_start;
		logic apply;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic need_div;
		logic div_busy;
	} stat_t;

	// a / 10 for an 8-bit value, reciprocal multiply (exact below 1029)
	function automatic logic [LVL_W-1:0] div10(input logic [LVL_W-1:0] a);
		logic [15:0] p;
		p = 16'(a) * 16'd205;
		return 8'(p >> 11);
	endfunction

	// steps between reports: (max - min) / 10 + 1, truncated toward zero, 8 bits
	function automatic logic [LVL_W-1:0] report_interval(
		input logic [LVL_W-1:0] lo,
		input logic [LVL_W-1:0] hi
	);
		logic [LVL_W-1:0] res;
		if (hi >= lo) begin
			res = div10(8'(hi - lo)) + 8'd1;
		end else begin
			res = 8'd1 - div10(8'(lo - hi));
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### src/dimmer_ramp_controller.sv
// Dimmer ramp controller.
// Input channel (in_valid/in_stall) carries one item per request: a
// millisecond tick or a command (stop, on, off, soft on/off, dim up/down,
// their toggles, set target, clear update flag). Every item gives exactly one
// result on the output channel (out_valid/out_stall): level, level_write,
// channel, supply_on, ramp_busy and update_ready as they stand after it.
// Configuration goes through cfg_write/cfg_index/cfg_data, one register per
// cycle; the user must write only while no item is in flight, as the block
// does not enforce it. Items are handled one at a time. A command or a tick
// that needs no new step period passes through the evaluate and apply
// states, and out_valid rises when the result is loaded. A tick that starts
// a stepped run also waits in the divide state for the bit-serial step
// period divider (15 quotient bits, one per cycle). The next item is accepted
// in the cycle after the result is loaded, even while that result is still stalled.
// A stalled result holds its payload; a further result waits in the apply
// step until the output register is free.
// Reset (arst_n low) clears the level, the task, the supply sequencer, the
// millisecond clock and loads the register defaults.
`default_nettype none
`include "dimmer_ramp_controller_assert.svh"
module dimmer_ramp_controller #(
	parameter int unsigned TIME_BITS = drc_pkg::TIME_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [drc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [drc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [drc_pkg::REQ_W-1:0]         req_type,
	input  wire logic [drc_pkg::LVL_W-1:0]         target_level,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [drc_pkg::LVL_W-1:0]              level,
	output logic                                   level_write,
	output logic [drc_pkg::LVL_W-1:0]              channel,
	output logic                                   supply_on,
	output logic                                   ramp_busy,
	output logic                                   update_ready
);

	drc_pkg::cmd_t  cmd;
	drc_pkg::stat_t stat;

	// sequencer
	drc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// datapath
	drc_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.target_level (target_level),
		.level        (level),
		.level_write  (level_write),
		.channel      (channel),
		.supply_on    (supply_on),
		.ramp_busy    (ramp_busy),
		.update_ready (update_ready)
	);

	// checks
	`DRC_ASSERT(a_accept_then_busy, (in_valid && !in_stall) |=> in_stall)
	`DRC_ASSERT(a_div_blocks_input, stat.div_busy |-> in_stall)
	`DRC_ASSERT(a_result_from_item, $rose(out_valid) |-> $past(in_stall))
	`DRC_NEVER(a_no_restart_mid_div, cmd.div_start && stat.div_busy)

endmodule
`default_nettype wire

### src/drc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module drc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [drc_pkg::DUR_W-1:0]   dividend,
	input  wire logic [drc_pkg::LVL_W-1:0]   divisor,
	output logic                             busy,
	output logic [drc_pkg::DUR_W-1:0]        quotient
);

	localparam int unsigned CNT_W = $clog2(drc_pkg::DUR_W);

	logic [drc_pkg::LVL_W-1:0] rem_q;
	logic [drc_pkg::LVL_W-1:0] dvs_q;
	logic [drc_pkg::DUR_W-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;

	logic [drc_pkg::LVL_W:0]   shifted;
	logic [drc_pkg::LVL_W:0]   diff;
	logic                      fits;

	// trial subtract of the shifted remainder
	always_comb begin
		shifted = {rem_q, quo_q[drc_pkg::DUR_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
	end

	// control: bit counter and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(drc_pkg::DUR_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[drc_pkg::LVL_W-1:0] : shifted[drc_pkg::LVL_W-1:0];
			quo_q <= {quo_q[drc_pkg::DUR_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### src/drc_ctrl.sv
`default_nettype none
// Sequencer: accept, evaluate, optional divide, apply and push the result.
module drc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            out_stall,
	input  wire drc_pkg::stat_t  stat,
	output drc_pkg::cmd_t        cmd,
	output logic                 in_stall,
	output logic                 out_valid
);

	drc_pkg::ctl_state_t state_q;
	drc_pkg::ctl_state_t state_nxt;
	logic                out_valid_q;
	logic                can_push;

	// output register free or emptied this cycle
	assign can_push = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			drc_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = drc_pkg::ST_EVAL;
			end
			drc_pkg::ST_EVAL: begin
				if (stat.need_div) state_nxt = drc_pkg::ST_DIV;
				else state_nxt = drc_pkg::ST_APPLY;
			end
			drc_pkg::ST_DIV: begin
				if (!stat.div_busy) state_nxt = drc_pkg::ST_APPLY;
			end
			drc_pkg::ST_APPLY: begin
				if (can_push) state_nxt = drc_pkg::ST_IDLE;
			end
			default: state_nxt = drc_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			drc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			drc_pkg::ST_EVAL: begin
				cmd.tick      = stat.is_tick;
				cmd.div_start = stat.need_div;
			end
			drc_pkg::ST_DIV: begin
				cmd = '0;
			end
			drc_pkg::ST_APPLY: begin
				cmd.apply = can_push;
			end
			default: cmd = '0;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.apply) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### src/drc_dp.sv
`default_nettype none
// Datapath: configuration, dimmer state, supply sequencer, output register.
module drc_dp #(
	parameter int unsigned TIME_BITS = drc_pkg::TIME_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire drc_pkg::cmd_t                     cmd,
	output drc_pkg::stat_t                         stat,
	input  wire logic                              cfg_write,
	input  wire logic [drc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [drc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [drc_pkg::REQ_W-1:0]         req_type,
	input  wire logic [drc_pkg::LVL_W-1:0]         target_level,
	output logic [drc_pkg::LVL_W-1:0]              level,
	output logic                                   level_write,
	output logic [drc_pkg::LVL_W-1:0]              channel,
	output logic                                   supply_on,
	output logic                                   ramp_busy,
	output logic                                   update_ready
);

	localparam int unsigned LW = drc_pkg::LVL_W;
	localparam int unsigned TW = TIME_BITS;

	// configuration registers
	logic [LW-1:0]                   min_q, max_q, chan_q;
	logic [drc_pkg::DUR_W-1:0]       abs_dur_q, rel_dur_q;
	logic [drc_pkg::ON_DLY_W-1:0]    on_dly_q;
	logic [drc_pkg::OFF_DLY_W-1:0]   off_dly_q;

	// latched item
	logic [drc_pkg::REQ_W-1:0]       req_q;
	logic [LW-1:0]                   tgt_q;

	// dimmer state
	logic [LW-1:0]                   lvl_q, cnt_q, goal_q;
	drc_pkg::task_t                  tsk_q;
	drc_pkg::phase_t                 phase_q;
	logic                            sup_q, busy_q, flag_q, dim_up_q;
	logic [drc_pkg::PER_W-1:0]       per_abs_q, per_rel_q;
	logic [TW-1:0]                   now_q, last_q, mark_q;

	// result register
	logic [LW-1:0]                   out_lvl_q, out_chan_q;
	logic                            out_wr_q, out_sup_q, out_busy_q, out_flag_q;

	// task decode
	logic                            do_ramp, ramp_up, ramp_rel, ramp_cnt;
	logic                            want_sup, to_stop, set_max, set_min, is_stop;
	logic [LW-1:0]                   gap;

	// divider
	logic                            div_busy;
	logic [drc_pkg::DUR_W-1:0]       quo;

	// next state
	logic [LW-1:0]                   lvl_n, cnt_n, goal_n, cnt_inc, interval;
	drc_pkg::task_t                  tsk_n;
	drc_pkg::phase_t                 phase_n;
	logic                            sup_n, busy_n, flag_n, dim_n, wrote;
	logic [TW-1:0]                   last_n, mark_n, el_step, el_sup;
	logic [drc_pkg::PER_W-1:0]       per_eff;
	logic                            step_ok, per_ld;
	logic                            is_tick;

	assign is_tick  = req_q == drc_pkg::REQ_TICK;
	assign interval = drc_pkg::report_interval(min_q, max_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= drc_pkg::RST_MIN_LEVEL;
			max_q     <= drc_pkg::RST_MAX_LEVEL;
			abs_dur_q <= drc_pkg::RST_ABS_DUR;
			rel_dur_q <= drc_pkg::RST_REL_DUR;
			on_dly_q  <= '0;
			off_dly_q <= '0;
			chan_q    <= '0;
		end else if (cfg_write) begin
			unique case (drc_pkg::cfg_reg_t'(cfg_index))
				drc_pkg::REG_MIN_LEVEL:  min_q     <= cfg_data[LW-1:0];
				drc_pkg::REG_MAX_LEVEL:  max_q     <= cfg_data[LW-1:0];
				drc_pkg::REG_ABS_DUR:    abs_dur_q <= cfg_data[drc_pkg::DUR_W-1:0];
				drc_pkg::REG_REL_DUR:    rel_dur_q <= cfg_data[drc_pkg::DUR_W-1:0];
				drc_pkg::REG_ON_DELAY:   on_dly_q  <= cfg_data[drc_pkg::ON_DLY_W-1:0];
				drc_pkg::REG_OFF_DELAY:  off_dly_q <= cfg_data[drc_pkg::OFF_DLY_W-1:0];
				drc_pkg::REG_CHANNEL_ID: chan_q    <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// what the selected task wants on a tick
	always_comb begin
		do_ramp  = 1'b0;
		ramp_up  = 1'b0;
		ramp_rel = 1'b0;
		ramp_cnt = 1'b0;
		want_sup = 1'b0;
		to_stop  = 1'b0;
		set_max  = 1'b0;
		set_min  = 1'b0;
		is_stop  = 1'b0;
		gap      = '0;
		unique case (tsk_q) inside
			drc_pkg::T_STOP: is_stop = 1'b1;
			drc_pkg::T_ON: begin
				if (lvl_q != max_q) begin
					if (phase_q == drc_pkg::PH_ON) set_max = 1'b1;
					else want_sup = 1'b1;
				end
			end
			drc_pkg::T_OFF: begin
				if (lvl_q != min_q) set_min = 1'b1;
			end
			drc_pkg::T_SOFTON, drc_pkg::T_UP: begin
				if (lvl_q < max_q) begin
					if (phase_q == drc_pkg::PH_ON) begin
						do_ramp  = 1'b1;
						ramp_up  = 1'b1;
						ramp_rel = tsk_q == drc_pkg::T_UP;
						ramp_cnt = tsk_q == drc_pkg::T_UP;
						gap      = max_q - lvl_q;
					end else begin
						want_sup = 1'b1;
					end
				end else begin
					to_stop = 1'b1;
				end
			end
			drc_pkg::T_SOFTOFF, drc_pkg::T_DOWN: begin
				if (lvl_q > min_q) begin
					do_ramp  = 1'b1;
					ramp_rel = tsk_q == drc_pkg::T_DOWN;
					ramp_cnt = tsk_q == drc_pkg::T_DOWN;
					gap      = lvl_q - min_q;
				end else begin
					to_stop = 1'b1;
				end
			end
			drc_pkg::T_SET: begin
				if (lvl_q < goal_q) begin
					if (phase_q == drc_pkg::PH_ON) begin
						do_ramp = 1'b1;
						ramp_up = 1'b1;
						gap     = goal_q - lvl_q;
					end else begin
						want_sup = 1'b1;
					end
				end else if (lvl_q > goal_q) begin
					do_ramp = 1'b1;
					gap     = lvl_q - goal_q;
				end else begin
					to_stop = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// step period = duration / distance, only when a run starts
	drc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (ramp_rel ? rel_dur_q : abs_dur_q),
		.divisor  (gap),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign stat.is_tick  = is_tick;
	assign stat.need_div = is_tick && do_ramp && !busy_q;
	assign stat.div_busy = div_busy;

	// period in force and elapsed step time
	assign per_eff = busy_q ? (ramp_rel ? per_rel_q : per_abs_q) : drc_pkg::PER_W'(quo);
	assign el_step = now_q - last_q;
	assign step_ok = 32'(el_step) >= 32'(per_eff);
	assign per_ld  = is_tick && do_ramp && !busy_q;
	assign cnt_inc = cnt_q + 8'd1;

	// next state of the item being applied
	always_comb begin
		lvl_n   = lvl_q;
		cnt_n   = cnt_q;
		goal_n  = goal_q;
		tsk_n   = tsk_q;
		phase_n = phase_q;
		sup_n   = sup_q;
		busy_n  = busy_q;
		flag_n  = flag_q;
		dim_n   = dim_up_q;
		last_n  = last_q;
		mark_n  = mark_q;
		wrote   = 1'b0;
		el_sup  = '0;
		if (is_tick) begin
			// task
			if (is_stop) begin
				busy_n = 1'b0;
				flag_n = 1'b1;
				cnt_n  = '0;
				tsk_n  = drc_pkg::T_IDLE;
				if (lvl_q == '0 && phase_q != drc_pkg::PH_OFF_WAIT &&
				    phase_q != drc_pkg::PH_OFF) begin
					mark_n  = now_q;
					phase_n = drc_pkg::PH_OFF_WAIT;
				end
				if (lvl_q == min_q) dim_n = 1'b1;
				if (lvl_q == max_q) dim_n = 1'b0;
			end
			if (set_max || set_min) begin
				lvl_n = set_max ? max_q : min_q;
				wrote = 1'b1;
				tsk_n = drc_pkg::T_STOP;
			end
			if (want_sup && phase_q != drc_pkg::PH_ON_WAIT) begin
				mark_n  = now_q;
				phase_n = drc_pkg::PH_ON_WAIT;
			end
			if (to_stop) tsk_n = drc_pkg::T_STOP;
			if (do_ramp && step_ok) begin
				lvl_n  = ramp_up ? lvl_q + 8'd1 : lvl_q - 8'd1;
				busy_n = 1'b1;
				wrote  = 1'b1;
				last_n = now_q;
				if (ramp_cnt) begin
					if (cnt_inc >= interval) begin
						flag_n = 1'b1;
						cnt_n  = '0;
					end else begin
						cnt_n = cnt_inc;
					end
				end
			end
			// supply sequencer
			el_sup = now_q - mark_n;
			if (phase_n == drc_pkg::PH_ON_WAIT) begin
				if (32'(el_sup) >= 32'(on_dly_q)) begin
					sup_n   = 1'b1;
					phase_n = drc_pkg::PH_ON;
				end
			end else if (phase_n == drc_pkg::PH_OFF_WAIT) begin
				if (32'(el_sup) >= off_dly_q) begin
					sup_n   = 1'b0;
					phase_n = drc_pkg::PH_OFF;
				end
			end
		end else begin
			// command items select a task; set also loads the goal, toggle dim flips the direction, clear drops the flag
			unique case (drc_pkg::req_t'(req_q))
				drc_pkg::REQ_STOP:     tsk_n = drc_pkg::T_STOP;
				drc_pkg::REQ_ON:       tsk_n = drc_pkg::T_ON;
				drc_pkg::REQ_OFF:      tsk_n = drc_pkg::T_OFF;
				drc_pkg::REQ_TOGGLE:
					tsk_n = (lvl_q != min_q) ? drc_pkg::T_OFF : drc_pkg::T_ON;
				drc_pkg::REQ_SOFT_ON:  tsk_n = drc_pkg::T_SOFTON;
				drc_pkg::REQ_SOFT_OFF: tsk_n = drc_pkg::T_SOFTOFF;
				drc_pkg::REQ_TOGGLE_SOFT:
					tsk_n = (lvl_q != min_q) ? drc_pkg::T_SOFTOFF : drc_pkg::T_SOFTON;
				drc_pkg::REQ_UP:       tsk_n = drc_pkg::T_UP;
				drc_pkg::REQ_DOWN:     tsk_n = drc_pkg::T_DOWN;
				drc_pkg::REQ_TOGGLE_DIM: begin
					tsk_n = dim_up_q ? drc_pkg::T_UP : drc_pkg::T_DOWN;
					dim_n = !dim_up_q;
				end
				drc_pkg::REQ_SET: begin
					goal_n = tgt_q;
					tsk_n  = drc_pkg::T_SET;
				end
				drc_pkg::REQ_CLEAR:    flag_n = 1'b0;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q     <= '0;
			cnt_q     <= '0;
			goal_q    <= '0;
			tsk_q     <= drc_pkg::T_IDLE;
			phase_q   <= drc_pkg::PH_OFF;
			sup_q     <= 1'b0;
			busy_q    <= 1'b0;
			flag_q    <= 1'b0;
			dim_up_q  <= 1'b1;
			per_abs_q <= '0;
			per_rel_q <= '0;
			now_q     <= '0;
			last_q    <= '0;
			mark_q    <= '0;
			req_q     <= '0;
			tgt_q     <= '0;
		end else begin
			if (cmd.load) begin
				req_q <= req_type;
				tgt_q <= target_level;
			end
			if (cmd.tick) now_q <= now_q + 1'b1;
			if (cmd.apply) begin
				lvl_q    <= lvl_n;
				cnt_q    <= cnt_n;
				goal_q   <= goal_n;
				tsk_q    <= tsk_n;
				phase_q  <= phase_n;
				sup_q    <= sup_n;
				busy_q   <= busy_n;
				flag_q   <= flag_n;
				dim_up_q <= dim_n;
				last_q   <= last_n;
				mark_q   <= mark_n;
				if (per_ld && !ramp_rel) per_abs_q <= drc_pkg::PER_W'(quo);
				if (per_ld && ramp_rel) per_rel_q <= drc_pkg::PER_W'(quo);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			out_lvl_q  <= lvl_n;
			out_wr_q   <= wrote;
			out_chan_q <= chan_q;
			out_sup_q  <= sup_n;
			out_busy_q <= busy_n;
			out_flag_q <= flag_n;
		end
	end

	assign level        = out_lvl_q;
	assign level_write  = out_wr_q;
	assign channel      = out_chan_q;
	assign supply_on    = out_sup_q;
	assign ramp_busy    = out_busy_q;
	assign update_ready = out_flag_q;

endmodule
`default_nettype wire

### bench/dimmer_level_checker.sv
`default_nettype none
// Watches the item, result and register ports of the dimmer ramp controller,
// predicts every result and compares it field by field.
module dimmer_level_checker #(
	parameter int unsigned TIME_BITS = drc_pkg::TIME_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [drc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [drc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [drc_pkg::REQ_W-1:0]      req_type,
	input  wire logic [drc_pkg::LVL_W-1:0]      target_level,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic [drc_pkg::LVL_W-1:0]      level,
	input  wire logic                           level_write,
	input  wire logic [drc_pkg::LVL_W-1:0]      channel,
	input  wire logic                           supply_on,
	input  wire logic                           ramp_busy,
	input  wire logic                           update_ready,
	output int                                  mismatches,
	output int                                  awaiting,
	output int                                  writes_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import drc_pkg::*;

	localparam logic [31:0] TIME_MASK = 32'((64'd1 << TIME_BITS) - 64'd1);

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             level_write;
		logic [LVL_W-1:0] channel;
		logic             supply_on;
		logic             ramp_busy;
		logic             update_ready;
	} dimmer_result_t;

	// register copies
	logic [LVL_W-1:0]     min_lvl, max_lvl, chan_id;
	logic [DUR_W-1:0]     abs_dur, rel_dur;
	logic [ON_DLY_W-1:0]  on_dly;
	logic [OFF_DLY_W-1:0] off_dly;

	// controller state as predicted
	logic [LVL_W-1:0] cur_lvl, goal_lvl, rep_count;
	task_t            sel_task;
	phase_t           sup_phase;
	logic             sup_on, busy, flag, dim_up, wrote;
	logic [PER_W-1:0] per_abs, per_rel;
	logic [31:0]      now_ms, last_step_ms, sup_mark_ms;

	dimmer_result_t pending_results[$];

	// elapsed milliseconds since a mark, modulo the clock width
	function automatic logic [31:0] since(input logic [31:0] mark);
		return (now_ms - mark) & TIME_MASK;
	endfunction

	// steps between update reports; span is signed, division truncates
	function automatic logic [LVL_W-1:0] report_every();
		int span;
		span = int'(max_lvl) - int'(min_lvl);
		return LVL_W'(span / 10 + 1);
	endfunction

	task automatic request_supply();
		if (sup_phase != PH_ON_WAIT) begin
			sup_mark_ms = now_ms;
			sup_phase = PH_ON_WAIT;
		end
	endtask

	// one stepped move; the period is fixed when a run starts (busy clear)
	task automatic step_toward(input logic up, input logic relative,
			input logic [LVL_W-1:0] gap);
		logic [DUR_W-1:0] dur;
		logic [PER_W-1:0] per;
		dur = relative ? rel_dur : abs_dur;
		if (!busy) begin
			if (relative)
				per_rel = PER_W'(dur / gap);
			else
				per_abs = PER_W'(dur / gap);
		end
		per = relative ? per_rel : per_abs;
		if (since(last_step_ms) >= 32'(per)) begin
			cur_lvl = up ? cur_lvl + 1'b1 : cur_lvl - 1'b1;
			busy = 1'b1;
			// only dim up/down count toward the report interval
			if (relative) begin
				rep_count = rep_count + 1'b1;
				if (rep_count >= report_every()) begin
					flag = 1'b1;
					rep_count = '0;
				end
			end
			wrote = 1'b1;
			last_step_ms = now_ms;
		end
	endtask

	// millisecond tick: advance the clock, run the task, then the supply
	task automatic advance_ms();
		now_ms = (now_ms + 1) & TIME_MASK;
		case (sel_task)
			T_STOP: begin
				busy = 1'b0;
				flag = 1'b1;
				rep_count = '0;
				sel_task = T_IDLE;
				if (cur_lvl == 0 && sup_phase != PH_OFF_WAIT && sup_phase != PH_OFF) begin
					sup_mark_ms = now_ms;
					sup_phase = PH_OFF_WAIT;
				end
				if (cur_lvl == min_lvl)
					dim_up = 1'b1;
				if (cur_lvl == max_lvl)
					dim_up = 1'b0;
			end
			T_ON: begin
				if (cur_lvl != max_lvl) begin
					if (sup_phase == PH_ON) begin
						cur_lvl = max_lvl;
						wrote = 1'b1;
						sel_task = T_STOP;
					end else begin
						request_supply();
					end
				end
			end
			T_OFF: begin
				if (cur_lvl != min_lvl) begin
					cur_lvl = min_lvl;
					wrote = 1'b1;
					sel_task = T_STOP;
				end
			end
			T_SOFTON, T_UP: begin
				if (cur_lvl < max_lvl) begin
					if (sup_phase == PH_ON)
						step_toward(1'b1, sel_task == T_UP, max_lvl - cur_lvl);
					else
						request_supply();
				end else begin
					sel_task = T_STOP;
				end
			end
			T_SOFTOFF, T_DOWN: begin
				if (cur_lvl > min_lvl)
					step_toward(1'b0, sel_task == T_DOWN, cur_lvl - min_lvl);
				else
					sel_task = T_STOP;
			end
			T_SET: begin
				if (cur_lvl < goal_lvl) begin
					if (sup_phase == PH_ON)
						step_toward(1'b1, 1'b0, goal_lvl - cur_lvl);
					else
						request_supply();
				end else if (cur_lvl > goal_lvl) begin
					step_toward(1'b0, 1'b0, cur_lvl - goal_lvl);
				end else begin
					sel_task = T_STOP;
				end
			end
			default: ;
		endcase

		// supply sequencer
		if (sup_phase == PH_ON_WAIT) begin
			if (since(sup_mark_ms) >= 32'(on_dly)) begin
				sup_on = 1'b1;
				sup_phase = PH_ON;
			end
		end else if (sup_phase == PH_OFF_WAIT) begin
			if (since(sup_mark_ms) >= off_dly) begin
				sup_on = 1'b0;
				sup_phase = PH_OFF;
			end
		end
	endtask

	// apply one item and build the result it gives
	task automatic next_dimmer_result(input logic [REQ_W-1:0] code,
			input logic [LVL_W-1:0] tgt, output dimmer_result_t res);
		wrote = 1'b0;
		case (code)
			REQ_TICK:        advance_ms();
			REQ_STOP:        sel_task = T_STOP;
			REQ_ON:          sel_task = T_ON;
			REQ_OFF:         sel_task = T_OFF;
			REQ_TOGGLE:      sel_task = (cur_lvl != min_lvl) ? T_OFF : T_ON;
			REQ_SOFT_ON:     sel_task = T_SOFTON;
			REQ_SOFT_OFF:    sel_task = T_SOFTOFF;
			REQ_TOGGLE_SOFT: sel_task = (cur_lvl != min_lvl) ? T_SOFTOFF : T_SOFTON;
			REQ_UP:          sel_task = T_UP;
			REQ_DOWN:        sel_task = T_DOWN;
			REQ_TOGGLE_DIM: begin
				sel_task = dim_up ? T_UP : T_DOWN;
				dim_up = !dim_up;
			end
			REQ_SET: begin
				goal_lvl = tgt;
				sel_task = T_SET;
			end
			REQ_CLEAR:       flag = 1'b0;
			default: ;
		endcase
		res = '{level: cur_lvl, level_write: wrote, channel: chan_id,
			supply_on: sup_on, ramp_busy: busy, update_ready: flag};
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dimmer_result_t want;
		dimmer_result_t fresh;
		if (!arst_n) begin
			min_lvl = RST_MIN_LEVEL;
			max_lvl = RST_MAX_LEVEL;
			abs_dur = RST_ABS_DUR;
			rel_dur = RST_REL_DUR;
			on_dly = '0;
			off_dly = '0;
			chan_id = '0;
			cur_lvl = '0;
			goal_lvl = '0;
			rep_count = '0;
			sel_task = T_IDLE;
			sup_phase = PH_OFF;
			sup_on = 1'b0;
			busy = 1'b0;
			flag = 1'b0;
			dim_up = 1'b1;
			wrote = 1'b0;
			per_abs = '0;
			per_rel = '0;
			now_ms = '0;
			last_step_ms = '0;
			sup_mark_ms = '0;
			pending_results.delete();
			mismatches = 0;
			awaiting = 0;
			writes_seen = 0;
		end else begin
			// register writes
			if (cfg_write) begin
				case (cfg_index)
					REG_MIN_LEVEL:  min_lvl = cfg_data[LVL_W-1:0];
					REG_MAX_LEVEL:  max_lvl = cfg_data[LVL_W-1:0];
					REG_ABS_DUR:    abs_dur = cfg_data[DUR_W-1:0];
					REG_REL_DUR:    rel_dur = cfg_data[DUR_W-1:0];
					REG_ON_DELAY:   on_dly = cfg_data[ON_DLY_W-1:0];
					REG_OFF_DELAY:  off_dly = cfg_data[OFF_DLY_W-1:0];
					REG_CHANNEL_ID: chan_id = cfg_data[LVL_W-1:0];
					default: ;
				endcase
			end

			// accepted result against the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no item waiting: level %0d", level);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					compare_field("level", want.level, level);
					compare_field("level_write", want.level_write, level_write);
					compare_field("channel", want.channel, channel);
					compare_field("supply_on", want.supply_on, supply_on);
					compare_field("ramp_busy", want.ramp_busy, ramp_busy);
					compare_field("update_ready", want.update_ready, update_ready);
				end
				if (level_write === 1'b1)
					writes_seen++;
			end

			// accepted item
			if (in_valid && !in_stall) begin
				next_dimmer_result(req_type, target_level, fresh);
				pending_results.push_back(fresh);
			end
			awaiting = pending_results.size();
		end
	end

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
// Drives commands and millisecond ticks into the dimmer ramp controller
// through several register settings; the checker predicts and compares.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import drc_pkg::*;

	localparam logic [REQ_W-1:0]     REQ_UNUSED_FIRST = 4'd13;
	localparam logic [REQ_W-1:0]     REQ_UNUSED_LAST  = 4'd15;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED       = 3'd7;
	localparam int                   SETTLE_CYCLES    = 20;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type = REQ_TICK;
	logic [LVL_W-1:0]      target_level = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [LVL_W-1:0]      level;
	logic                  level_write;
	logic [LVL_W-1:0]      channel;
	logic                  supply_on;
	logic                  ramp_busy;
	logic                  update_ready;

	int mismatches;
	int awaiting;
	int writes_seen;
	bit idling = 1'b1;
	int items_sent = 0;
	int ticks_sent = 0;
	int settings_used = 0;

	dimmer_ramp_controller dut (.*);

	dimmer_level_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls in random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// send one item, with an occasional idle burst ahead of it
	task automatic send_item(input logic [REQ_W-1:0] code, input logic [LVL_W-1:0] tgt);
		if (idling && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= code;
		target_level <= tgt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (code <= REQ_CLEAR)
			items_sent++;
		if (code == REQ_TICK)
			ticks_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait until every result is back and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// new register setting, then random command/tick traffic
	task automatic run_phase(input logic [LVL_W-1:0] lo, input logic [LVL_W-1:0] hi,
			input logic [DUR_W-1:0] absd, input logic [DUR_W-1:0] reld,
			input logic [ON_DLY_W-1:0] ondly, input logic [OFF_DLY_W-1:0] offdly,
			input logic [LVL_W-1:0] chan, input bit idle, input int count);
		logic [CFG_DATA_W-1:0] regval [2**CFG_IDX_W];
		int start;
		int pick;
		drain();
		// junk above each register's width must be dropped
		regval[REG_MIN_LEVEL]  = {24'($urandom), lo};
		regval[REG_MAX_LEVEL]  = {24'($urandom), hi};
		regval[REG_ABS_DUR]    = {17'($urandom), absd};
		regval[REG_REL_DUR]    = {17'($urandom), reld};
		regval[REG_ON_DELAY]   = {16'($urandom), ondly};
		regval[REG_OFF_DELAY]  = offdly;
		regval[REG_CHANNEL_ID] = {24'($urandom), chan};
		regval[REG_UNUSED]     = $urandom;
		for (int i = 0; i < 2**CFG_IDX_W; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= regval[i];
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		settings_used++;
		idling = idle;
		start = items_sent;
		while (items_sent - start < count) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				// a command followed by a run of ticks that lets it work
				send_item(4'($urandom_range(REQ_STOP, REQ_SET)), 8'($urandom));
				repeat ($urandom_range(1, 48)) send_item(REQ_TICK, 8'($urandom));
			end else if (pick < 17) begin
				send_item(REQ_CLEAR, 8'($urandom));
			end else if (pick < 18) begin
				send_item(4'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)), 8'($urandom));
			end else begin
				// back-to-back command, reselects mid-run
				send_item(4'($urandom_range(REQ_STOP, REQ_CLEAR)), 8'($urandom));
			end
		end
	endtask

	initial begin
		logic [REQ_W-1:0] opening [28];
		opening = '{
			REQ_TICK, REQ_UNUSED_FIRST, REQ_UNUSED_LAST, REQ_CLEAR,
			REQ_ON, REQ_TICK, REQ_TICK, REQ_TICK, REQ_ON, REQ_TICK,
			REQ_TOGGLE, REQ_TICK, REQ_TICK, REQ_SET, REQ_TICK, REQ_TICK,
			REQ_SOFT_OFF, REQ_TICK, REQ_UP, REQ_TICK, REQ_DOWN, REQ_TOGGLE_DIM,
			REQ_TOGGLE_SOFT, REQ_TICK, REQ_STOP, REQ_TICK, REQ_SET, REQ_TICK
		};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed start on reset defaults: on to full, on at full, toggle off,
		// set to full, reselection while busy; first set aims at 255, second at 0
		foreach (opening[i])
			send_item(opening[i], (i < 20) ? 8'hFF : 8'h00);

		run_phase(8'd0, 8'd255, 15'd40, 15'd90, 16'd3, 32'd5, 8'd255, 1'b1, 200);
		run_phase(8'd20, 8'd200, 15'd0, 15'd0, 16'd0, 32'd0, 8'h5A, 1'b1, 200);
		// inverted range
		run_phase(8'd255, 8'd0, 15'd10, 15'd30, 16'd1, 32'd2, 8'd1, 1'b0, 180);
		// longest durations and delays, empty range
		run_phase(8'd80, 8'd80, 15'd32767, 15'd32767, 16'd65535, 32'hFFFF_FFFF, 8'hA5,
			1'b1, 80);
		run_phase(8'd0, 8'd255, 15'd100, 15'd300, 16'd0, 32'd0, 8'($urandom), 1'b1, 200);
		run_phase(8'd5, 8'd250, 15'd20, 15'd60, 16'd2, 32'd10, 8'($urandom), 1'b1, 180);
		run_phase(8'd0, 8'd1, 15'd1, 15'd1, 16'd0, 32'd0, 8'd0, 1'b1, 150);
		run_phase(8'($urandom_range(0, 60)), 8'($urandom_range(150, 255)),
			15'($urandom_range(0, 400)), 15'($urandom_range(0, 1000)),
			16'($urandom_range(0, 20)), 32'($urandom_range(0, 50)), 8'($urandom), 1'b1, 200);
		// closing stretch with no idling on either side
		run_phase(8'd0, 8'd255, 15'd30, 15'd100, 16'd1, 32'd1, 8'd7, 1'b0, 200);
		drain();

		$display("%0d commands and ticks (%0d ticks) over %0d register settings",
			items_sent, ticks_sent, settings_used);
		$display("%0d results carried a level write", writes_seen);
		if (mismatches == 0)
			$display("dimmer_ramp_controller: match");
		else
			$display("dimmer_ramp_controller: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("dimmer_ramp_controller: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
